FILE: sv/assert_macros.svh
// Assertion macros used by hpm_ctrl.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/hpm_pkg.sv
// ----------------------------------------------------------------------------
// hpm_pkg
// Shared types, codes and tables of the HARQ process manager.
// ----------------------------------------------------------------------------
package hpm_pkg;

  // Request kinds.
  localparam logic [1:0] FUNC_NEW     = 2'd0;
  localparam logic [1:0] FUNC_FEEDBCK = 2'd1;
  localparam logic [1:0] FUNC_TIMEOUT = 2'd2;
  localparam logic [1:0] FUNC_CLEAR   = 2'd3;

  // Result status codes.
  localparam logic [2:0] STAT_NEW     = 3'd0;
  localparam logic [2:0] STAT_ACK     = 3'd1;
  localparam logic [2:0] STAT_RETX    = 3'd2;
  localparam logic [2:0] STAT_FAILED  = 3'd3;
  localparam logic [2:0] STAT_IGNORED = 3'd4;
  localparam logic [2:0] STAT_NO_FREE = 3'd5;
  localparam logic [2:0] STAT_CLEARED = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_HARQ_EN  = 2'd0;
  localparam logic [1:0] CFG_PROC_LOG = 2'd1;
  localparam logic [1:0] CFG_MAX_RETX = 2'd2;

  // Per-process record held in the process memory.
  typedef struct packed {
    logic [1:0]  rv_idx;
    logic [3:0]  retx;
    logic [15:0] bytes;
    logic [4:0]  mcs;
  } proc_rec_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic exec;
    logic done;
  } hpm_cmd_t;

  // Redundancy version sequence 0, 2, 3, 1.
  function automatic logic [1:0] rv_order(input logic [1:0] idx);
    logic [1:0] rv;
    unique case (idx)
      2'd0: rv = 2'd0;
      2'd1: rv = 2'd2;
      2'd2: rv = 2'd3;
      default: rv = 2'd1;
    endcase
    return rv;
  endfunction

endpackage

FILE: sv/hpm_ram.sv
// ----------------------------------------------------------------------------
// hpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: sv/hpm_ctrl.sv
// ----------------------------------------------------------------------------
// hpm_ctrl
// Sequencer of the HARQ process manager: latch, read, execute, report.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hpm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output hpm_pkg::hpm_cmd_t cmd_o
);
  import hpm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EXEC = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands and handshake.
  assign busy        = (state_q != S_IDLE);
  assign cmd_o.latch = (state_q == S_IDLE) && start;
  assign cmd_o.exec  = (state_q == S_EXEC);
  assign cmd_o.done  = (state_q == S_DONE);

  `ASSERT_NEXT(a_accept_reads, start && !busy, state_q == S_READ)
  `ASSERT_NEXT(a_done_one_cycle, state_q == S_DONE, state_q == S_IDLE && !busy)
  `ASSERT_IMPL(a_exec_after_read, state_q == S_EXEC, $past(state_q) == S_READ)

endmodule

FILE: sv/hpm_datapath.sv
// ----------------------------------------------------------------------------
// hpm_datapath
// Process table, statistics and configuration of the HARQ process manager.
// ----------------------------------------------------------------------------
module hpm_datapath #(
  parameter int NUM_UES   = 8,
  parameter int MAX_PROCS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hpm_pkg::hpm_cmd_t cmd_i,
  input  logic              cfg_valid_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [3:0]        cfg_data_i,
  input  logic [1:0]        func_i,
  input  logic [2:0]        ue_i,
  input  logic [4:0]        process_id_i,
  input  logic              ack_i,
  input  logic [15:0]       size_bytes_i,
  input  logic [4:0]        mcs_i,
  output logic              done_o,
  output logic [2:0]        status_o,
  output logic [4:0]        result_process_o,
  output logic [1:0]        redundancy_version_o,
  output logic [3:0]        retx_count_o,
  output logic [15:0]       tx_size_o,
  output logic [4:0]        tx_mcs_o,
  output logic [5:0]        free_count_o,
  output logic [31:0]       total_tx_o,
  output logic [31:0]       total_retx_o,
  output logic [31:0]       total_ack_o,
  output logic [31:0]       total_nack_o,
  output logic [31:0]       total_dropped_o
);
  import hpm_pkg::*;

  localparam int UE_AW = (NUM_UES > 1) ? $clog2(NUM_UES) : 1;
  localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int DEPTH = NUM_UES * MAX_PROCS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Process count for a log2 setting, with the log2 capped at five and the count at MAX_PROCS.
  function automatic logic [5:0] proc_count(input logic [2:0] lg);
    logic [2:0] l;
    logic [5:0] p;
    l = (lg > 3'd5) ? 3'd5 : lg;
    p = 6'd1 << l;
    if (32'(p) > MAX_PROCS) begin
      p = 6'(MAX_PROCS);
    end
    return p;
  endfunction

  // Configuration registers.
  logic       harq_en_q;
  logic [2:0] proc_log_q;
  logic [3:0] max_retx_q;
  logic       tbl_clr_cfg;

  assign tbl_clr_cfg = cfg_valid_i && (cfg_index_i == CFG_PROC_LOG)
                       && (proc_count(cfg_data_i[2:0]) != proc_count(proc_log_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      harq_en_q  <= 1'b1;
      proc_log_q <= 3'd3;
      max_retx_q <= 4'd3;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_HARQ_EN:  harq_en_q  <= cfg_data_i[0];
        CFG_PROC_LOG: proc_log_q <= cfg_data_i[2:0];
        CFG_MAX_RETX: max_retx_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Latched request.
  logic [1:0]  func_q;
  logic [2:0]  ue_q;
  logic [4:0]  pid_q;
  logic        ack_q;
  logic [15:0] size_q;
  logic [4:0]  mcs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      func_q <= func_i;
      ue_q   <= ue_i;
      pid_q  <= process_id_i;
      ack_q  <= ack_i;
      size_q <= size_bytes_i;
      mcs_q  <= mcs_i;
    end
  end

  // Waiting flags, one per process; a process that is not waiting is free.
  logic [MAX_PROCS-1:0] wait_q [NUM_UES];
  logic [5:0]           pcount;
  logic [MAX_PROCS-1:0] pmask;
  logic [MAX_PROCS-1:0] row_bits;
  logic [UE_AW-1:0]     row;
  logic                 ue_ok;
  logic                 pid_ok;
  logic [PW-1:0]        pid_w;

  assign pcount = proc_count(proc_log_q);
  assign row    = UE_AW'(ue_q);
  assign ue_ok  = (32'(ue_q) < NUM_UES);
  assign pid_w  = PW'(pid_q);
  assign pid_ok = ue_ok && (6'(pid_q) < pcount);

  always_comb begin
    for (int i = 0; i < MAX_PROCS; i++) begin
      pmask[i] = (32'(i) < 32'(pcount));
    end
    row_bits = ue_ok ? wait_q[row] : '0;
  end

  // Lowest free process of the UE.
  logic          found;
  logic [PW-1:0] alloc_idx;

  always_comb begin
    found     = 1'b0;
    alloc_idx = '0;
    for (int i = MAX_PROCS - 1; i >= 0; i--) begin
      if (pmask[i] && !row_bits[i]) begin
        found     = ue_ok;
        alloc_idx = PW'(i);
      end
    end
  end

  // Process memory.
  proc_rec_t     rd_rec;
  proc_rec_t     wr_rec;
  logic          ram_we;
  logic [PW-1:0] target;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;

  assign raddr = AW'(32'(row) * MAX_PROCS + 32'(pid_w));
  assign waddr = AW'(32'(row) * MAX_PROCS + 32'(target));

  hpm_ram #(
    .WIDTH($bits(proc_rec_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wr_rec),
    .raddr_i(raddr),
    .rdata_o(rd_rec)
  );

  // Step of one request.
  logic       waiting;
  logic       show;
  logic       set_wait;
  logic       clr_wait;
  logic       clr_all;
  logic [2:0] status_d;
  logic [4:0] rproc_d;
  logic       inc_tx, inc_retx, inc_ack, inc_nack, inc_drop;

  assign waiting = pid_ok && row_bits[pid_w];

  always_comb begin
    show     = 1'b0;
    set_wait = 1'b0;
    clr_wait = 1'b0;
    clr_all  = 1'b0;
    ram_we   = 1'b0;
    target   = pid_w;
    wr_rec   = rd_rec;
    status_d = STAT_IGNORED;
    rproc_d  = pid_q;
    inc_tx   = 1'b0;
    inc_retx = 1'b0;
    inc_ack  = 1'b0;
    inc_nack = 1'b0;
    inc_drop = 1'b0;
    unique case (func_q)
      FUNC_NEW: begin
        rproc_d = '0;
        status_d = STAT_NO_FREE;
        if (found) begin
          target        = alloc_idx;
          show          = 1'b1;
          set_wait      = 1'b1;
          ram_we        = 1'b1;
          wr_rec.rv_idx = 2'd0;
          wr_rec.retx   = 4'd0;
          wr_rec.bytes  = size_q;
          wr_rec.mcs    = mcs_q;
          inc_tx        = 1'b1;
          status_d      = STAT_NEW;
          rproc_d       = 5'(alloc_idx);
        end
      end
      FUNC_CLEAR: begin
        clr_all  = 1'b1;
        status_d = STAT_CLEARED;
        rproc_d  = '0;
      end
      default: begin
        if (waiting) begin
          show   = 1'b1;
          ram_we = 1'b1;
          if (func_q == FUNC_FEEDBCK && ack_q) begin
            inc_ack      = 1'b1;
            clr_wait     = 1'b1;
            wr_rec.bytes = '0;
            status_d     = STAT_ACK;
          end else if (!harq_en_q) begin
            inc_nack     = (func_q == FUNC_FEEDBCK);
            inc_drop     = 1'b1;
            clr_wait     = 1'b1;
            wr_rec.bytes = '0;
            status_d     = STAT_FAILED;
          end else begin
            inc_nack = 1'b1;
            if (rd_rec.retx >= max_retx_q) begin
              clr_wait     = 1'b1;
              wr_rec.bytes = '0;
              status_d     = STAT_FAILED;
            end else begin
              wr_rec.rv_idx = rd_rec.rv_idx + 2'd1;
              wr_rec.retx   = rd_rec.retx + 4'd1;
              inc_retx      = 1'b1;
              status_d      = STAT_RETX;
            end
          end
        end
      end
    endcase
    ram_we = ram_we && cmd_i.exec;
  end

  // Waiting flags update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int u = 0; u < NUM_UES; u++) begin
        wait_q[u] <= '0;
      end
    end else if (tbl_clr_cfg || (cmd_i.exec && clr_all)) begin
      for (int u = 0; u < NUM_UES; u++) begin
        wait_q[u] <= '0;
      end
    end else if (cmd_i.exec && set_wait) begin
      wait_q[row][target] <= 1'b1;
    end else if (cmd_i.exec && clr_wait) begin
      wait_q[row][target] <= 1'b0;
    end
  end

  // Statistic counters.
  logic [31:0] tx_q, retx_q, ack_cnt_q, nack_q, drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q      <= '0;
      retx_q    <= '0;
      ack_cnt_q <= '0;
      nack_q    <= '0;
      drop_q    <= '0;
    end else if (cmd_i.exec) begin
      if (clr_all) begin
        tx_q      <= '0;
        retx_q    <= '0;
        ack_cnt_q <= '0;
        nack_q    <= '0;
        drop_q    <= '0;
      end else begin
        tx_q      <= tx_q + 32'(inc_tx);
        retx_q    <= retx_q + 32'(inc_retx);
        ack_cnt_q <= ack_cnt_q + 32'(inc_ack);
        nack_q    <= nack_q + 32'(inc_nack);
        drop_q    <= drop_q + 32'(inc_drop);
      end
    end
  end

  // Result registers.
  logic [2:0]  status_q;
  logic [4:0]  rproc_q;
  logic [1:0]  rv_q;
  logic [3:0]  retxo_q;
  logic [15:0] bytes_q;
  logic [4:0]  mcso_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      status_q <= status_d;
      rproc_q  <= rproc_d;
      rv_q     <= show ? rv_order(wr_rec.rv_idx) : 2'd0;
      retxo_q  <= show ? wr_rec.retx : 4'd0;
      bytes_q  <= show ? wr_rec.bytes : 16'd0;
      mcso_q   <= show ? wr_rec.mcs : 5'd0;
    end
  end

  // Free processes of the UE after the step.
  logic [5:0] free_cnt;

  always_comb begin
    free_cnt = '0;
    for (int i = 0; i < MAX_PROCS; i++) begin
      free_cnt = free_cnt + 6'(pmask[i] && !row_bits[i]);
    end
    if (!ue_ok) begin
      free_cnt = '0;
    end
  end

  assign done_o               = cmd_i.done;
  assign status_o             = status_q;
  assign result_process_o     = rproc_q;
  assign redundancy_version_o = rv_q;
  assign retx_count_o         = retxo_q;
  assign tx_size_o            = bytes_q;
  assign tx_mcs_o             = mcso_q;
  assign free_count_o         = free_cnt;
  assign total_tx_o           = tx_q;
  assign total_retx_o         = retx_q;
  assign total_ack_o          = ack_cnt_q;
  assign total_nack_o         = nack_q;
  assign total_dropped_o      = drop_q;

endmodule

FILE: sv/harq_process_manager.sv
// ----------------------------------------------------------------------------
// harq_process_manager
// HARQ process table per UE with incremental redundancy and statistics.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Each request runs
// through latch, process memory read, execute and write back, then a result
// state in which done_o is high for exactly one clock; the receiver cannot
// stall it. The registered read of the process memory calls for the separate
// read step. Configuration writes are always accepted (cfg_ready_o is high) and
// must only be issued while busy is low. Changing the process count clears
// the table at once; there is no clearing pass after reset.
module harq_process_manager #(
  parameter int NUM_UES   = 8,
  parameter int MAX_PROCS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [2:0]  ue_i,
  input  logic [4:0]  process_id_i,
  input  logic        ack_i,
  input  logic [15:0] size_bytes_i,
  input  logic [4:0]  mcs_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [3:0]  cfg_data_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [4:0]  result_process_o,
  output logic [1:0]  redundancy_version_o,
  output logic [3:0]  retx_count_o,
  output logic [15:0] tx_size_o,
  output logic [4:0]  tx_mcs_o,
  output logic [5:0]  free_count_o,
  output logic [31:0] total_tx_o,
  output logic [31:0] total_retx_o,
  output logic [31:0] total_ack_o,
  output logic [31:0] total_nack_o,
  output logic [31:0] total_dropped_o
);
  import hpm_pkg::*;

  hpm_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  // Sequencer.
  hpm_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .cmd_o (cmd)
  );

  // Table, counters and configuration.
  hpm_datapath #(
    .NUM_UES  (NUM_UES),
    .MAX_PROCS(MAX_PROCS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .func_i              (func_i),
    .ue_i                (ue_i),
    .process_id_i        (process_id_i),
    .ack_i               (ack_i),
    .size_bytes_i        (size_bytes_i),
    .mcs_i               (mcs_i),
    .done_o              (done_o),
    .status_o            (status_o),
    .result_process_o    (result_process_o),
    .redundancy_version_o(redundancy_version_o),
    .retx_count_o        (retx_count_o),
    .tx_size_o           (tx_size_o),
    .tx_mcs_o            (tx_mcs_o),
    .free_count_o        (free_count_o),
    .total_tx_o          (total_tx_o),
    .total_retx_o        (total_retx_o),
    .total_ack_o         (total_ack_o),
    .total_nack_o        (total_nack_o),
    .total_dropped_o     (total_dropped_o)
  );

endmodule
